FILE: rtl/gird_pkg.sv
// ----------------------------------------------------------------------------
// gird_pkg: shared types and constants of the gamepad report decoder
// Word layouts, report geometry, register indexes and stick scaling helpers.
// ----------------------------------------------------------------------------
package gird_pkg;

  // Report geometry
  localparam int REPORT_LEN     = 362;
  localparam int POS_W          = $clog2(REPORT_LEN + 1);
  localparam int POS_ID         = 0;
  localparam int POS_BTN_FIRST  = 3;
  localparam int POS_STICK_LAST = 11;
  localparam int POS_IMU_FIRST  = 37;
  localparam int POS_IMU_LAST   = 48;
  localparam int CAP_IMU_BASE   = 9;
  localparam int CAP_N          = 21;
  localparam int CAP_IDX_W      = $clog2(CAP_N);

  // Report ids
  localparam logic [7:0] ID_FULL  = 8'h30;
  localparam logic [7:0] ID_REPLY = 8'h21;

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CENTER_W   = 12;
  localparam logic [CFG_IDX_W-1:0] REG_X_CENTER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_Y_CENTER = CFG_IDX_W'(1);
  localparam logic [CENTER_W-1:0]  X_CENTER_RST = CENTER_W'(2048);
  localparam logic [CENTER_W-1:0]  Y_CENTER_RST = CENTER_W'(1950);

  // Stick scaling: |d| / 12 == (|d| * 2731) >> 15 for |d| <= 4095
  localparam int RECIP_12    = 2731;
  localparam int RECIP_SHIFT = 15;
  localparam int PROD_W      = 2 * CENTER_W;
  localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

  // IMU scaling
  localparam int ACCEL_W   = 24;
  localparam int RATE_W    = 23;
  localparam int ACCEL_MUL = 244;
  localparam int GYRO_MUL  = 70;

  typedef struct packed {
    logic [7:0] report_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [23:0]               button_bits;
    logic signed [7:0]         left_x;
    logic signed [7:0]         left_y;
    logic signed [7:0]         right_x;
    logic signed [7:0]         right_y;
    logic                      motion_valid;
    logic signed [ACCEL_W-1:0] accel_x;
    logic signed [ACCEL_W-1:0] accel_y;
    logic signed [ACCEL_W-1:0] accel_z;
    logic signed [RATE_W-1:0]  rate_x;
    logic signed [RATE_W-1:0]  rate_y;
    logic signed [RATE_W-1:0]  rate_z;
  } out_word_t;

  // One finished report, already known to carry an accepted id
  typedef struct packed {
    logic                  full_id;
    logic [CAP_N-1:0][7:0] cap;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Signed, clamped stick axis from magnitude quotient and result sign
  function automatic logic signed [7:0] axis_clamp(input logic neg_res,
                                                   input logic [QUOT_W-1:0] q);
    logic signed [7:0] r;
    if (neg_res) begin
      if (q >= QUOT_W'(128)) r = -8'sd128;
      else                   r = 8'(~q[7:0] + 8'd1);
    end else begin
      if (q >= QUOT_W'(127)) r = 8'sd127;
      else                   r = q[7:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/gamepad_input_report_decoder_core.sv
// ----------------------------------------------------------------------------
// gamepad_input_report_decoder_core: controller input report decoder
// Byte-serial report parser producing buttons, scaled sticks and IMU data.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: write one report byte per word with in_push while in_full
//   is low; in_word.last_byte marks the final byte of a report. Any byte
//   rate up to one word per cycle is sustained while in_full is low.
//   Result channel: a report with id 0x30 or 0x21 yields one result word,
//   visible on out_word while out_empty is low, taken with out_pop. Other
//   ids yield nothing. Results pass the job queue, decode and output queue;
//   one report per cycle (one-byte reports) is sustained with out_pop high.
//   Configuration: write stick centers through cfg_valid/cfg_index/cfg_data
//   while the block is idle; cfg_ready is always high.
//   Reset (rst_n low, synchronous): position, captures and queues clear, the
//   centers return to 2048 and 1950.
//   Stall: when out_pop stays low, the two-entry result queue and the decode
//   pipeline fill, then the two-entry job queue fills and in_full rises.
//   While both job slots are taken every byte is held, also bytes in the
//   middle of a report, until decode frees a slot.
// ----------------------------------------------------------------------------
module gamepad_input_report_decoder_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  gird_pkg::in_word_t               in_word,
  output logic                             out_empty,
  input  logic                             out_pop,
  output gird_pkg::out_word_t              out_word,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gird_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gird_pkg::CENTER_W-1:0]    cfg_data
);

  logic [gird_pkg::CENTER_W-1:0] h_mid_r;
  logic [gird_pkg::CENTER_W-1:0] v_mid_r;

  logic              in_accept;
  logic              job_push;
  logic              job_pop;
  gird_pkg::job_t    job_in;
  gird_pkg::job_t    job_head;
  gird_pkg::q_stat_t job_stat;

  // Hold the input side whenever both job slots are taken
  assign in_full   = job_stat.full;
  assign in_accept = in_push && !in_full;
  assign cfg_ready = 1'b1;

  // Stick center registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_mid_r <= gird_pkg::X_CENTER_RST;
      v_mid_r <= gird_pkg::Y_CENTER_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gird_pkg::REG_X_CENTER: h_mid_r <= cfg_data;
        gird_pkg::REG_Y_CENTER: v_mid_r <= cfg_data;
        default: ;
      endcase
    end
  end

  gird_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_word   (in_word),
    .job_push  (job_push),
    .job_word  (job_in)
  );

  gird_job_queue u_job_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_word (job_in),
    .pop       (job_pop),
    .head_word (job_head),
    .stat      (job_stat)
  );

  gird_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .h_mid     (h_mid_r),
    .v_mid     (v_mid_r),
    .job_empty (job_stat.empty),
    .job_word  (job_head),
    .job_pop   (job_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_word  (out_word)
  );

endmodule

FILE: rtl/gird_front.sv
// ----------------------------------------------------------------------------
// gird_front: report byte capture
// Tracks byte position, captures id, button, stick and IMU bytes, and emits
// one job per report whose id is accepted.
// ----------------------------------------------------------------------------
module gird_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_accept,
  input  gird_pkg::in_word_t in_word,
  output logic               job_push,
  output gird_pkg::job_t     job_word
);

  logic [gird_pkg::POS_W-1:0]            pos_r, pos_nxt;
  logic [7:0]                            kind_r, kind_nxt;
  logic [gird_pkg::CAP_N-1:0][7:0]       cap_r, cap_nxt;
  logic                                  in_range;
  logic                                  id_ok;
  logic                                  end_of_report;

  always_comb begin
    pos_nxt  = pos_r;
    kind_nxt = kind_r;
    cap_nxt  = cap_r;
    in_range = pos_r < gird_pkg::POS_W'(gird_pkg::REPORT_LEN);
    if (in_accept && in_range) begin
      if (pos_r == gird_pkg::POS_W'(gird_pkg::POS_ID)) begin
        kind_nxt = in_word.report_byte;
      end else if (pos_r >= gird_pkg::POS_W'(gird_pkg::POS_BTN_FIRST) &&
                   pos_r <= gird_pkg::POS_W'(gird_pkg::POS_STICK_LAST)) begin
        cap_nxt[gird_pkg::CAP_IDX_W'(pos_r - gird_pkg::POS_W'(gird_pkg::POS_BTN_FIRST))] =
          in_word.report_byte;
      end else if (pos_r >= gird_pkg::POS_W'(gird_pkg::POS_IMU_FIRST) &&
                   pos_r <= gird_pkg::POS_W'(gird_pkg::POS_IMU_LAST)) begin
        cap_nxt[gird_pkg::CAP_IDX_W'(pos_r - gird_pkg::POS_W'(gird_pkg::POS_IMU_FIRST -
                                                              gird_pkg::CAP_IMU_BASE))] =
          in_word.report_byte;
      end
      pos_nxt = pos_r + gird_pkg::POS_W'(1);
    end
  end

  assign end_of_report = in_accept && in_word.last_byte;
  assign id_ok = (kind_nxt == gird_pkg::ID_FULL) || (kind_nxt == gird_pkg::ID_REPLY);
  assign job_push = end_of_report && id_ok;
  assign job_word.full_id = (kind_nxt == gird_pkg::ID_FULL);
  assign job_word.cap = cap_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      kind_r <= '0;
      cap_r  <= '0;
    end else if (end_of_report) begin
      // clear position and captures, keep the id
      pos_r  <= '0;
      kind_r <= kind_nxt;
      cap_r  <= '0;
    end else begin
      pos_r  <= pos_nxt;
      kind_r <= kind_nxt;
      cap_r  <= cap_nxt;
    end
  end

endmodule

FILE: rtl/gird_job_queue.sv
// ----------------------------------------------------------------------------
// gird_job_queue: two-entry queue between capture and decode
// Decouples the byte capture from the decode pipeline.
// ----------------------------------------------------------------------------
module gird_job_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  gird_pkg::job_t    push_word,
  input  logic              pop,
  output gird_pkg::job_t    head_word,
  output gird_pkg::q_stat_t stat
);

  gird_pkg::job_t ent_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_word  = ent_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop)      cnt_nxt = cnt_r + 2'd1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wp_r] <= push_word;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("job queue count overflow");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("decode popped an empty job queue");
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> !stat.empty)
    else $error("pushed job lost");

endmodule

FILE: rtl/gird_back.sv
// ----------------------------------------------------------------------------
// gird_back: report decode pipeline
// Centers and scales the sticks, scales the IMU sample, and holds results
// in a two-entry output queue.
// ----------------------------------------------------------------------------
module gird_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [gird_pkg::CENTER_W-1:0]   h_mid,
  input  logic [gird_pkg::CENTER_W-1:0]   v_mid,
  input  logic                            job_empty,
  input  gird_pkg::job_t                  job_word,
  output logic                            job_pop,
  input  logic                            out_pop,
  output logic                            out_empty,
  output gird_pkg::out_word_t             out_word
);

  localparam int CW = gird_pkg::CENTER_W;
  localparam int PW = gird_pkg::PROD_W;
  localparam int AW = gird_pkg::ACCEL_W;
  localparam int RW = gird_pkg::RATE_W;

  // stage 1: magnitudes times reciprocal, IMU products
  logic                   s1_v_r;
  logic [23:0]            s1_btn_r;
  logic [3:0]             s1_neg_r;
  logic [3:0][PW-1:0]     s1_prod_r;
  logic                   s1_mv_r;
  logic [2:0][AW-1:0]     s1_acc_r;
  logic [2:0][RW-1:0]     s1_rate_r;

  logic [3:0][CW-1:0]     raw;
  logic [3:0][CW-1:0]     ctr;
  logic [3:0]             neg;
  logic [3:0][PW-1:0]     prod;
  logic [2:0][AW-1:0]     acc;
  logic [2:0][RW-1:0]     rate;

  // stage 2: finished result word
  logic                   s2_v_r;
  gird_pkg::out_word_t    s2_word_r;
  gird_pkg::out_word_t    s2_nxt;

  // output queue
  gird_pkg::out_word_t    oq_r [2];
  logic                   oq_wp_r, oq_rp_r;
  logic [1:0]             oq_cnt_r;
  logic                   oq_push, oq_pop;
  logic                   advance;

  assign oq_push = s2_v_r && (oq_cnt_r != 2'd2);
  assign oq_pop  = out_pop && (oq_cnt_r != 2'd0);
  assign advance = !s2_v_r || oq_push;
  assign job_pop = advance && !job_empty;

  always_comb begin
    logic [CW:0]   d;
    logic [CW-1:0] mag;
    logic [15:0]   imu;
    raw[0] = {job_word.cap[4][3:0], job_word.cap[3]};
    raw[1] = {job_word.cap[5], job_word.cap[4][7:4]};
    raw[2] = {job_word.cap[7][3:0], job_word.cap[6]};
    raw[3] = {job_word.cap[8], job_word.cap[7][7:4]};
    ctr[0] = h_mid;
    ctr[1] = v_mid;
    ctr[2] = h_mid;
    ctr[3] = v_mid;
    for (int i = 0; i < 4; i++) begin
      d       = {1'b0, raw[i]} - {1'b0, ctr[i]};
      neg[i]  = d[CW];
      mag     = neg[i] ? CW'(-d) : d[CW-1:0];
      prod[i] = {{(PW - CW){1'b0}}, mag} * PW'(gird_pkg::RECIP_12);
    end
    for (int k = 0; k < 3; k++) begin
      imu     = {job_word.cap[gird_pkg::CAP_IMU_BASE + 2 * k + 1],
                 job_word.cap[gird_pkg::CAP_IMU_BASE + 2 * k]};
      acc[k]  = {{(AW - 16){imu[15]}}, imu} * AW'(gird_pkg::ACCEL_MUL);
      imu     = {job_word.cap[gird_pkg::CAP_IMU_BASE + 6 + 2 * k + 1],
                 job_word.cap[gird_pkg::CAP_IMU_BASE + 6 + 2 * k]};
      rate[k] = {{(RW - 16){imu[15]}}, imu} * RW'(gird_pkg::GYRO_MUL);
    end
  end

  always_comb begin
    s2_nxt.button_bits  = s1_btn_r;
    // x keeps the sign of the offset, y flips it
    s2_nxt.left_x  = gird_pkg::axis_clamp(s1_neg_r[0],
                                          s1_prod_r[0][PW-1:gird_pkg::RECIP_SHIFT]);
    s2_nxt.left_y  = gird_pkg::axis_clamp(!s1_neg_r[1],
                                          s1_prod_r[1][PW-1:gird_pkg::RECIP_SHIFT]);
    s2_nxt.right_x = gird_pkg::axis_clamp(s1_neg_r[2],
                                          s1_prod_r[2][PW-1:gird_pkg::RECIP_SHIFT]);
    s2_nxt.right_y = gird_pkg::axis_clamp(!s1_neg_r[3],
                                          s1_prod_r[3][PW-1:gird_pkg::RECIP_SHIFT]);
    s2_nxt.motion_valid = s1_mv_r;
    s2_nxt.accel_x = s1_acc_r[0];
    s2_nxt.accel_y = s1_acc_r[1];
    s2_nxt.accel_z = s1_acc_r[2];
    s2_nxt.rate_x  = s1_rate_r[0];
    s2_nxt.rate_y  = s1_rate_r[1];
    s2_nxt.rate_z  = s1_rate_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      oq_wp_r  <= 1'b0;
      oq_rp_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      if (advance) begin
        s1_v_r <= job_pop;
        s2_v_r <= s1_v_r;
      end
      if (oq_push) oq_wp_r <= ~oq_wp_r;
      if (oq_pop)  oq_rp_r <= ~oq_rp_r;
      if (oq_push && !oq_pop)      oq_cnt_r <= oq_cnt_r + 2'd1;
      else if (oq_pop && !oq_push) oq_cnt_r <= oq_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_btn_r  <= {job_word.cap[2], job_word.cap[1], job_word.cap[0]};
      s1_neg_r  <= neg;
      s1_prod_r <= prod;
      s1_mv_r   <= job_word.full_id;
      // drop motion data for reply reports
      s1_acc_r  <= job_word.full_id ? acc : '0;
      s1_rate_r <= job_word.full_id ? rate : '0;
      s2_word_r <= s2_nxt;
    end
    if (oq_push) oq_r[oq_wp_r] <= s2_word_r;
  end

  assign out_empty = (oq_cnt_r == 2'd0);
  assign out_word  = oq_r[oq_rp_r];

  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n) oq_cnt_r <= 2'd2)
    else $error("output queue count overflow");
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !advance) |=> (s2_v_r && $stable(s2_word_r)))
    else $error("stalled result changed");
  a_no_motion_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !s2_word_r.motion_valid) |->
      (s2_word_r.accel_x == '0 && s2_word_r.rate_z == '0))
    else $error("reply report carries motion data");

endmodule
